// ----- src/two_level_direct_mapped_cache_unit_macros.svh -----
// Assertion macros for the two-level cache unit checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef TWO_LEVEL_DIRECT_MAPPED_CACHE_UNIT_MACROS_SVH
`define TWO_LEVEL_DIRECT_MAPPED_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define TDMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held.
`define TDMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tdmc_pkg.sv -----
// Package for the two-level cache unit: geometry, codes, states and structs.
// Depends on nothing; imported by every module of the block but tdmc_ram.
package tdmc_pkg;

    localparam int WORDS_PER_LINE = 16;
    localparam int L1_LINE_COUNT  = 256;
    localparam int L2_LINE_COUNT  = 512;
    localparam int STORE_WORDS    = 65536;

    localparam int ADDR_W   = $clog2(STORE_WORDS);
    localparam int OFF_W    = $clog2(WORDS_PER_LINE);
    localparam int BLK_W    = ADDR_W - OFF_W;
    localparam int L1_IDX_W = $clog2(L1_LINE_COUNT);
    localparam int L1_TAG_W = BLK_W - L1_IDX_W;
    localparam int L2_IDX_W = $clog2(L2_LINE_COUNT);
    localparam int L2_TAG_W = BLK_W - L2_IDX_W;
    localparam int CNT_W    = OFF_W + 1;
    localparam int DATA_W   = 32;
    localparam int COST_W   = 8;
    localparam int ACC_W    = 11;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 3;
    localparam int CFG_N    = 6;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORDS_PER_LINE);

    typedef enum logic [CFG_W-1:0] {
        CFG_L1_RD = 3'd0,
        CFG_L1_WR = 3'd1,
        CFG_L2_RD = 3'd2,
        CFG_L2_WR = 3'd3,
        CFG_ST_RD = 3'd4,
        CFG_ST_WR = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L1_REQ,
        ST_L1_LOOK,
        ST_L2_REQ,
        ST_L2_LOOK,
        ST_L2_WB,
        ST_STORE_FILL,
        ST_L2_XFER,
        ST_L1_FILL,
        ST_WORD,
        ST_WORD_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [L1_TAG_W-1:0] tag;
    } l1_meta_t;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [L2_TAG_W-1:0] tag;
    } l2_meta_t;

    typedef struct packed {
        logic in_fire;
        logic l1_hit;
        logic l1_victim_dirty;
        logic l2_hit;
        logic l2_victim_dirty;
        logic op_wr;
        logic out_free;
    } seq_status_t;

    typedef struct packed {
        logic copy_wen;
        logic copy_last;
        logic clear_last;
        logic in_ready;
    } seq_flags_t;

endpackage

// ----- src/tdmc_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
module tdmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tdmc_cost.sv -----
// Cost accumulator: per-transaction cost and wrapping running total.
// Depends on tdmc_pkg.
module tdmc_cost
    import tdmc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               charge_en,
    input  logic [COST_W-1:0]  charge_amt,
    output logic [ACC_W-1:0]   step_cost,
    output logic [TOTAL_W-1:0] elapsed
);

    logic [ACC_W-1:0]   step_reg,  step_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    always_comb begin
        step_next  = step_reg;
        total_next = total_reg;
        if (start) begin
            step_next = '0;
        end else if (charge_en) begin
            step_next  = step_reg + ACC_W'(charge_amt);
            total_next = total_reg + TOTAL_W'(charge_amt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            total_reg <= '0;
        end else begin
            step_reg  <= step_next;
            total_reg <= total_next;
        end
    end

    assign step_cost = step_reg;
    assign elapsed   = total_reg;

endmodule

// ----- src/tdmc_seq.sv -----
// Sequencer: state machine, word counter of the copy unit, clear counter.
// Depends on tdmc_pkg.
module tdmc_seq
    import tdmc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  seq_status_t       status,
    output state_t            state,
    output logic [CNT_W-1:0]  cnt,
    output logic [ADDR_W-1:0] clr,
    output seq_flags_t        flags
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [ADDR_W-1:0] clr_reg,   clr_next;
    logic              copying;

    // outputs
    always_comb begin
        copying = (state_reg == ST_L2_WB) || (state_reg == ST_STORE_FILL) ||
                  (state_reg == ST_L2_XFER) || (state_reg == ST_L1_FILL);
        flags.copy_wen   = copying && (cnt_reg != '0);
        flags.copy_last  = copying && (cnt_reg == CNT_LAST);
        flags.clear_last = (state_reg == ST_CLEAR) && (&clr_reg);
        flags.in_ready   = (state_reg == ST_IDLE);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:      if (flags.clear_last) state_next = ST_IDLE;
            ST_IDLE:       if (status.in_fire) state_next = ST_L1_REQ;
            ST_L1_REQ:     state_next = ST_L1_LOOK;
            ST_L1_LOOK:    state_next = status.l1_hit ? ST_WORD : ST_L2_REQ;
            ST_L2_REQ:     state_next = ST_L2_LOOK;
            ST_L2_LOOK: begin
                priority if (status.l2_hit) state_next = ST_L2_XFER;
                else if (status.l2_victim_dirty) state_next = ST_L2_WB;
                else state_next = ST_STORE_FILL;
            end
            ST_L2_WB:      if (flags.copy_last) state_next = ST_STORE_FILL;
            ST_STORE_FILL: if (flags.copy_last) state_next = ST_L2_XFER;
            ST_L2_XFER: begin
                if (flags.copy_last) begin
                    state_next = (!status.op_wr && status.l1_victim_dirty) ?
                                 ST_L2_REQ : ST_L1_FILL;
                end
            end
            ST_L1_FILL:    if (flags.copy_last) state_next = ST_WORD;
            ST_WORD:       state_next = ST_WORD_RD;
            ST_WORD_RD:    state_next = ST_DONE;
            ST_DONE:       if (status.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = (copying && !flags.copy_last) ? cnt_reg + 1'b1 : '0;
        clr_next = (state_reg == ST_CLEAR) ? clr_reg + 1'b1 : clr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    assign state = state_reg;
    assign cnt   = cnt_reg;
    assign clr   = clr_reg;

endmodule

// ----- src/two_level_direct_mapped_cache_unit.sv -----
// Top level of the two-level direct-mapped write-back cache unit.
// Depends on tdmc_pkg, tdmc_ram, tdmc_cost and tdmc_seq.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_opcode, s_word_address, s_write_word
//  m_       out        m_valid / m_ready   m_read_data, m_l1_hit, m_l2_hit,
//                                          m_access_cost, m_total_time
//  cfg_     in         cfg_we (no wait)    cfg_addr, cfg_wdata
//
// One transaction at a time. Each line move is one pass through the shared
// word-copy unit, and a miss takes two to seven passes (the fewest for a
// clean miss that hits L2, the most with both victims dirty and both L2
// look-ups missing). After reset a clearing pass over all STORE_WORDS
// addresses zeroes the backing store and all tag state; s_ready stays low
// meanwhile, config writes are taken. A finished result sits in the output
// register while the next transaction is accepted; only the final result
// load waits on m_ready.
module two_level_direct_mapped_cache_unit
    import tdmc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [ADDR_W-1:0]  s_word_address,
    input  logic [DATA_W-1:0]  s_write_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DATA_W-1:0]  m_read_data,
    output logic               m_l1_hit,
    output logic               m_l2_hit,
    output logic [ACC_W-1:0]   m_access_cost,
    output logic [TOTAL_W-1:0] m_total_time,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_addr,
    input  logic [COST_W-1:0]  cfg_wdata
);

    state_t            state;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] clr;
    seq_flags_t        flags;
    seq_status_t       status;

    logic [COST_W-1:0] cost_reg [CFG_N];

    // latched request
    logic              req_wr_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [DATA_W-1:0] req_wdata_reg;

    // working context
    l1_meta_t          l1m_reg;
    logic [L2_TAG_W-1:0] l2vtag_reg;
    logic [BLK_W-1:0]  op_blk_reg;
    logic              op_wr_reg;
    logic              l2hit_reg;
    logic              l1hit_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] buf_reg [WORDS_PER_LINE];
    logic [DATA_W-1:0] buf_rd_reg;

    // output register
    logic               m_valid_reg;
    logic [DATA_W-1:0]  m_data_reg;
    logic               m_l1_reg, m_l2_reg;
    logic [ACC_W-1:0]   m_cost_reg;
    logic [TOTAL_W-1:0] m_total_reg;

    logic [BLK_W-1:0]    req_blk;
    logic [L1_IDX_W-1:0] req_idx;
    logic [L1_TAG_W-1:0] req_tag;
    logic [OFF_W-1:0]    req_off;
    logic [OFF_W-1:0]    wcnt;
    logic [L2_IDX_W-1:0] op_idx;
    logic [L2_TAG_W-1:0] op_tag;
    logic                in_fire, out_free, step_load;

    // memory ports
    logic                 l1d_we, l2d_we, st_we, l1m_we, l2m_we;
    logic [L1_IDX_W+OFF_W-1:0] l1d_waddr, l1d_raddr;
    logic [L2_IDX_W+OFF_W-1:0] l2d_waddr, l2d_raddr;
    logic [ADDR_W-1:0]    st_waddr, st_raddr;
    logic [L1_IDX_W-1:0]  l1m_waddr;
    logic [L2_IDX_W-1:0]  l2m_waddr;
    logic [DATA_W-1:0]    l1d_wdata, l2d_wdata, st_wdata;
    logic [DATA_W-1:0]    l1d_rdata, l2d_rdata, st_rdata;
    l1_meta_t             l1m_wdata, l1m_rdata;
    l2_meta_t             l2m_wdata, l2m_rdata;

    logic                 charge_en;
    logic [COST_W-1:0]    charge_amt;
    logic [ACC_W-1:0]     step_cost;
    logic [TOTAL_W-1:0]   elapsed;

    assign in_fire  = s_valid && flags.in_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = flags.in_ready;

    assign req_blk = req_addr_reg[ADDR_W-1:OFF_W];
    assign req_off = req_addr_reg[OFF_W-1:0];
    assign req_idx = req_blk[L1_IDX_W-1:0];
    assign req_tag = req_blk[BLK_W-1:L1_IDX_W];
    assign op_idx  = op_blk_reg[L2_IDX_W-1:0];
    assign op_tag  = op_blk_reg[BLK_W-1:L2_IDX_W];
    assign wcnt    = OFF_W'(cnt - 1'b1);

    // Status for the sequencer; look-up results come straight off the tag reads.
    always_comb begin
        status.in_fire         = in_fire;
        status.l1_hit          = l1m_rdata.valid && (l1m_rdata.tag == req_tag);
        status.l1_victim_dirty = l1m_reg.valid && l1m_reg.dirty;
        status.l2_hit          = l2m_rdata.valid && (l2m_rdata.tag == op_tag);
        status.l2_victim_dirty = l2m_rdata.valid && l2m_rdata.dirty;
        status.op_wr           = op_wr_reg;
        status.out_free        = out_free;
    end

    tdmc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .state   (state),
        .cnt     (cnt),
        .clr     (clr),
        .flags   (flags)
    );

    // Config registers; writes beyond the last index drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg[CFG_L1_RD] <= 8'd1;
            cost_reg[CFG_L1_WR] <= 8'd1;
            cost_reg[CFG_L2_RD] <= 8'd10;
            cost_reg[CFG_L2_WR] <= 8'd10;
            cost_reg[CFG_ST_RD] <= 8'd100;
            cost_reg[CFG_ST_WR] <= 8'd100;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_L1_RD: cost_reg[CFG_L1_RD] <= cfg_wdata;
                CFG_L1_WR: cost_reg[CFG_L1_WR] <= cfg_wdata;
                CFG_L2_RD: cost_reg[CFG_L2_RD] <= cfg_wdata;
                CFG_L2_WR: cost_reg[CFG_L2_WR] <= cfg_wdata;
                CFG_ST_RD: cost_reg[CFG_ST_RD] <= cfg_wdata;
                CFG_ST_WR: cost_reg[CFG_ST_WR] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Memory addressing and write steering for each state of the sequencer.
    always_comb begin
        l1d_we    = 1'b0;
        l2d_we    = 1'b0;
        st_we     = 1'b0;
        l1m_we    = 1'b0;
        l2m_we    = 1'b0;
        l1d_waddr = {req_idx, wcnt};
        l1d_raddr = {req_idx, cnt[OFF_W-1:0]};
        l2d_waddr = {op_idx, wcnt};
        l2d_raddr = {op_idx, cnt[OFF_W-1:0]};
        st_waddr  = {l2vtag_reg, op_idx, wcnt};
        st_raddr  = {op_blk_reg, cnt[OFF_W-1:0]};
        l1m_waddr = req_idx;
        l2m_waddr = op_idx;
        l1d_wdata = buf_rd_reg;
        l2d_wdata = st_rdata;
        st_wdata  = l2d_rdata;
        l1m_wdata = '{valid: 1'b1, dirty: 1'b0, tag: req_tag};
        l2m_wdata = '{valid: 1'b1, dirty: 1'b0, tag: op_tag};
        charge_en  = 1'b0;
        charge_amt = cost_reg[CFG_L1_RD];
        unique case (state)
            ST_CLEAR: begin
                // zero the store and every tag entry
                st_we     = 1'b1;
                st_waddr  = clr;
                st_wdata  = '0;
                l1m_we    = 1'b1;
                l1m_waddr = clr[L1_IDX_W-1:0];
                l1m_wdata = '0;
                l2m_we    = 1'b1;
                l2m_waddr = clr[L2_IDX_W-1:0];
                l2m_wdata = '0;
            end
            ST_L2_WB: begin
                // dirty L2 victim back to the store
                st_we      = flags.copy_wen;
                charge_en  = flags.copy_last;
                charge_amt = cost_reg[CFG_ST_WR];
            end
            ST_STORE_FILL: begin
                l2d_we     = flags.copy_wen;
                l2m_we     = flags.copy_last;
                charge_en  = flags.copy_last;
                charge_amt = cost_reg[CFG_ST_RD];
            end
            ST_L2_XFER: begin
                // write: L1 victim line into L2; read: L2 line into the fill buffer
                l2d_we     = flags.copy_wen && op_wr_reg;
                l2d_wdata  = l1d_rdata;
                l2m_we     = flags.copy_last && op_wr_reg;
                l2m_wdata  = '{valid: 1'b1, dirty: 1'b1, tag: op_tag};
                charge_en  = flags.copy_last;
                charge_amt = op_wr_reg ? cost_reg[CFG_L2_WR] : cost_reg[CFG_L2_RD];
            end
            ST_L1_FILL: begin
                l1d_we = flags.copy_wen;
                l1m_we = flags.copy_last;
            end
            ST_WORD: begin
                l1d_raddr  = {req_idx, req_off};
                l1d_waddr  = {req_idx, req_off};
                l1d_wdata  = req_wdata_reg;
                l1d_we     = req_wr_reg;
                l1m_we     = req_wr_reg;
                l1m_wdata  = '{valid: 1'b1, dirty: 1'b1, tag: req_tag};
                charge_en  = 1'b1;
                charge_amt = req_wr_reg ? cost_reg[CFG_L1_WR] : cost_reg[CFG_L1_RD];
            end
            default: ;
        endcase
    end

    tdmc_ram #(.WIDTH(DATA_W), .DEPTH(L1_LINE_COUNT * WORDS_PER_LINE)) u_l1_data (
        .aclk (aclk), .we (l1d_we), .waddr (l1d_waddr), .wdata (l1d_wdata),
        .raddr (l1d_raddr), .rdata (l1d_rdata)
    );

    tdmc_ram #(.WIDTH(DATA_W), .DEPTH(L2_LINE_COUNT * WORDS_PER_LINE)) u_l2_data (
        .aclk (aclk), .we (l2d_we), .waddr (l2d_waddr), .wdata (l2d_wdata),
        .raddr (l2d_raddr), .rdata (l2d_rdata)
    );

    tdmc_ram #(.WIDTH(DATA_W), .DEPTH(STORE_WORDS)) u_store (
        .aclk (aclk), .we (st_we), .waddr (st_waddr), .wdata (st_wdata),
        .raddr (st_raddr), .rdata (st_rdata)
    );

    tdmc_ram #(.WIDTH($bits(l1_meta_t)), .DEPTH(L1_LINE_COUNT)) u_l1_meta (
        .aclk (aclk), .we (l1m_we), .waddr (l1m_waddr), .wdata (l1m_wdata),
        .raddr (req_idx), .rdata (l1m_rdata)
    );

    tdmc_ram #(.WIDTH($bits(l2_meta_t)), .DEPTH(L2_LINE_COUNT)) u_l2_meta (
        .aclk (aclk), .we (l2m_we), .waddr (l2m_waddr), .wdata (l2m_wdata),
        .raddr (op_idx), .rdata (l2m_rdata)
    );

    assign step_load = in_fire;

    tdmc_cost u_cost (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (step_load),
        .charge_en  (charge_en),
        .charge_amt (charge_amt),
        .step_cost  (step_cost),
        .elapsed    (elapsed)
    );

    // Fill buffer: capture L2 words on a read transfer, replay them into L1.
    always_ff @(posedge aclk) begin
        if (state == ST_L2_XFER && !op_wr_reg && flags.copy_wen) begin
            buf_reg[wcnt] <= l2d_rdata;
        end
        buf_rd_reg <= buf_reg[cnt[OFF_W-1:0]];
    end

    // Request and working context.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_wr_reg    <= s_opcode;
            req_addr_reg  <= s_word_address;
            req_wdata_reg <= s_write_word;
        end
        if (state == ST_L1_LOOK) begin
            l1m_reg    <= l1m_rdata;
            op_blk_reg <= req_blk;
        end
        if (state == ST_L2_LOOK) begin
            l2vtag_reg <= l2m_rdata.tag;
        end
        // after the fill read, retarget the unit at the L1 victim (written back if dirty)
        if (state == ST_L2_XFER && flags.copy_last && !op_wr_reg) begin
            op_blk_reg <= {l1m_reg.tag, req_idx};
        end
        if (state == ST_WORD_RD) begin
            rdata_reg <= req_wr_reg ? '0 : l1d_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_wr_reg <= 1'b0;
            l2hit_reg <= 1'b0;
            l1hit_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                op_wr_reg <= 1'b0;
                l2hit_reg <= 1'b0;
            end
            if (state == ST_L1_LOOK) begin
                l1hit_reg <= status.l1_hit;
            end
            if (state == ST_L2_LOOK && !op_wr_reg) begin
                l2hit_reg <= status.l2_hit;
            end
            if (state == ST_L2_XFER && flags.copy_last && !op_wr_reg) begin
                op_wr_reg <= 1'b1;
            end
        end
    end

    // Output register: load when the slot frees, hold until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state == ST_DONE && out_free) begin
            m_data_reg  <= rdata_reg;
            m_l1_reg    <= l1hit_reg;
            m_l2_reg    <= l2hit_reg;
            m_cost_reg  <= step_cost;
            m_total_reg <= elapsed;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_data_reg;
    assign m_l1_hit      = m_l1_reg;
    assign m_l2_hit      = m_l2_reg;
    assign m_access_cost = m_cost_reg;
    assign m_total_time  = m_total_reg;

endmodule

// ----- src/tdmc_checker.sv -----
// Port-level checker for the two-level cache unit, bound to the top level.
// Depends on tdmc_pkg and two_level_direct_mapped_cache_unit_macros.svh.
`include "two_level_direct_mapped_cache_unit_macros.svh"

module tdmc_checker
    import tdmc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_l1_hit,
    input logic               m_l2_hit,
    input logic [TOTAL_W-1:0] m_total_time
);

    // A stalled result holds its total.
    `TDMC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_total_time), "result changed while stalled")

    // An accepted transaction keeps the unit busy on the next cycle.
    `TDMC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after accept")

    // An L1 hit never reports an L2 hit.
    `TDMC_ASSERT_NOW(a_hit_excl, m_valid && m_l1_hit, !m_l2_hit, "L1 and L2 hit together")

endmodule

bind two_level_direct_mapped_cache_unit tdmc_checker u_tdmc_checker (.*);

// ----- test/tb_two_level_direct_mapped_cache_unit.sv -----
// Self-checking testbench for two_level_direct_mapped_cache_unit: directed and random
// word reads and writes, checked against an in-bench model of both cache levels.
// Depends on tdmc_pkg and the RTL of the block; reads no files.
module tb_two_level_direct_mapped_cache_unit;
    import tdmc_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    // Register indexes past the last cost register; writes there must be dropped.
    localparam logic [CFG_W-1:0] CFG_PAST_LAST_A = CFG_W'(CFG_N);
    localparam logic [CFG_W-1:0] CFG_PAST_LAST_B = CFG_W'(CFG_N + 1);

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               l1_hit;
        logic               l2_hit;
        logic [ACC_W-1:0]   access_cost;
        logic [TOTAL_W-1:0] total_time;
    } access_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_opcode;
    logic [ADDR_W-1:0]  s_word_address;
    logic [DATA_W-1:0]  s_write_word;
    logic               m_valid;
    logic               m_ready;
    logic [DATA_W-1:0]  m_read_data;
    logic               m_l1_hit;
    logic               m_l2_hit;
    logic [ACC_W-1:0]   m_access_cost;
    logic [TOTAL_W-1:0] m_total_time;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_addr;
    logic [COST_W-1:0]  cfg_wdata;

    two_level_direct_mapped_cache_unit dut (.*);

    // ---------------------------------------------------------------------
    // Shadow copy of the cache hierarchy
    // ---------------------------------------------------------------------
    logic [COST_W-1:0]   cost_reg [CFG_N] = '{8'd1, 8'd1, 8'd10, 8'd10, 8'd100, 8'd100};
    logic [DATA_W-1:0]   l1_data [L1_LINE_COUNT*WORDS_PER_LINE];
    logic [L1_TAG_W-1:0] l1_tag [L1_LINE_COUNT] = '{default: '0};
    bit                  l1_valid [L1_LINE_COUNT] = '{default: 0};
    bit                  l1_dirty [L1_LINE_COUNT] = '{default: 0};
    logic [DATA_W-1:0]   l2_data [L2_LINE_COUNT*WORDS_PER_LINE];
    logic [L2_TAG_W-1:0] l2_tag [L2_LINE_COUNT] = '{default: '0};
    bit                  l2_valid [L2_LINE_COUNT] = '{default: 0};
    bit                  l2_dirty [L2_LINE_COUNT] = '{default: 0};
    logic [DATA_W-1:0]   backing [STORE_WORDS] = '{default: '0};
    logic [TOTAL_W-1:0]  elapsed = '0;
    logic [31:0]         step_cost;
    // Line buffers between levels.
    logic [DATA_W-1:0]   store_buf [WORDS_PER_LINE];
    logic [DATA_W-1:0]   l2_in_buf [WORDS_PER_LINE];
    logic [DATA_W-1:0]   l2_out_buf [WORDS_PER_LINE];

    access_result_t pending_results [$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [ADDR_W-1:0] hot_addr [8] = '{default: '0};

    function automatic void charge_cost(logic [COST_W-1:0] c);
        step_cost += c;
        elapsed   += c;
    endfunction

    // Move one block between the backing store and L2 line l2_line.
    function automatic void store_transfer(int blk, bit wr, int l2_line);
        int a;
        for (int i = 0; i < WORDS_PER_LINE; i++) begin
            a = (blk * WORDS_PER_LINE + i) % STORE_WORDS;
            if (wr)
                backing[a] = l2_data[l2_line*WORDS_PER_LINE + i];
            else
                store_buf[i] = backing[a];
        end
        charge_cost(wr ? cost_reg[CFG_ST_WR] : cost_reg[CFG_ST_RD]);
    endfunction

    // Block read (into l2_out_buf) or write (from l2_in_buf) at L2; returns the hit.
    function automatic bit l2_transfer(int blk, bit wr);
        int idx;
        int tg;
        bit hit;
        idx = blk % L2_LINE_COUNT;
        tg  = blk / L2_LINE_COUNT;
        hit = l2_valid[idx] && l2_tag[idx] == tg;
        if (!hit) begin
            store_transfer(blk, 1'b0, idx);
            if (l2_valid[idx] && l2_dirty[idx])
                store_transfer(l2_tag[idx] * L2_LINE_COUNT + idx, 1'b1, idx);
            for (int i = 0; i < WORDS_PER_LINE; i++)
                l2_data[idx*WORDS_PER_LINE + i] = store_buf[i];
            l2_valid[idx] = 1;
            l2_tag[idx]   = tg;
            l2_dirty[idx] = 0;
        end
        for (int i = 0; i < WORDS_PER_LINE; i++) begin
            if (wr)
                l2_data[idx*WORDS_PER_LINE + i] = l2_in_buf[i];
            else
                l2_out_buf[i] = l2_data[idx*WORDS_PER_LINE + i];
        end
        if (wr) begin
            l2_dirty[idx] = 1;
            charge_cost(cost_reg[CFG_L2_WR]);
        end else begin
            charge_cost(cost_reg[CFG_L2_RD]);
        end
        return hit;
    endfunction

    // Run one word access through the shadow hierarchy and queue its result.
    function automatic void predict_access(logic op, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] wdata);
        int blk;
        int off;
        int idx;
        int tg;
        int base;
        access_result_t r;
        blk  = addr / WORDS_PER_LINE;
        off  = addr % WORDS_PER_LINE;
        idx  = blk % L1_LINE_COUNT;
        tg   = blk / L1_LINE_COUNT;
        base = idx * WORDS_PER_LINE;
        r = '0;
        step_cost = 0;
        r.l1_hit = l1_valid[idx] && l1_tag[idx] == tg;
        if (!r.l1_hit) begin
            r.l2_hit = l2_transfer(blk, 1'b0);
            if (l1_valid[idx] && l1_dirty[idx]) begin
                for (int i = 0; i < WORDS_PER_LINE; i++)
                    l2_in_buf[i] = l1_data[base + i];
                void'(l2_transfer(l1_tag[idx] * L1_LINE_COUNT + idx, 1'b1));
            end
            for (int i = 0; i < WORDS_PER_LINE; i++)
                l1_data[base + i] = l2_out_buf[i];
            l1_valid[idx] = 1;
            l1_tag[idx]   = tg;
            l1_dirty[idx] = 0;
        end
        if (op == OP_WRITE) begin
            l1_data[base + off] = wdata;
            l1_dirty[idx] = 1;
            charge_cost(cost_reg[CFG_L1_WR]);
        end else begin
            r.read_data = l1_data[base + off];
            charge_cost(cost_reg[CFG_L1_RD]);
        end
        r.access_cost = step_cost[ACC_W-1:0];
        r.total_time  = elapsed;
        pending_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------------
    // Clock, timeout, receiver and result checker
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Drop m_ready at random according to the current stall rate.
    always @(negedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        access_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_read_data !== e.read_data) begin
                    $error("read_data: expected %h, got %h", e.read_data, m_read_data);
                    fail_count++;
                end
                if (m_l1_hit !== e.l1_hit) begin
                    $error("l1_hit: expected %b, got %b", e.l1_hit, m_l1_hit);
                    fail_count++;
                end
                if (m_l2_hit !== e.l2_hit) begin
                    $error("l2_hit: expected %b, got %b", e.l2_hit, m_l2_hit);
                    fail_count++;
                end
                if (m_access_cost !== e.access_cost) begin
                    $error("access_cost: expected %0d, got %0d", e.access_cost,
                           m_access_cost);
                    fail_count++;
                end
                if (m_total_time !== e.total_time) begin
                    $error("total_time: expected %0d, got %0d", e.total_time,
                           m_total_time);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Shared driving tasks; each is entered and left at a falling edge
    // ---------------------------------------------------------------------
    task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
        int gap;
        // Insert an idle stretch before this transaction now and then.
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_word_address <= addr;
        s_write_word   <= wdata;
        // Hold the payload until the handshake completes.
        do @(posedge aclk); while (!s_ready);
        predict_access(op, addr, wdata);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every queued result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_cost(logic [CFG_W-1:0] idx, logic [COST_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx < CFG_N)
            cost_reg[idx] = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_all_costs(logic [COST_W-1:0] value);
        for (int i = 0; i < CFG_N; i++)
            write_cost(CFG_W'(i), value);
    endtask

    // Mostly addresses crowded onto a few L1 lines so that tags collide in both
    // levels, plus a hot set for repeat hits and fully random addresses.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(3))
            0: a = ADDR_W'($urandom);
            1, 2: begin
                a = {L1_TAG_W'($urandom_range(15)), L1_IDX_W'($urandom_range(3)),
                     OFF_W'($urandom)};
                if ($urandom_range(3) == 0)
                    hot_addr[$urandom_range(7)] = a;
            end
            default: a = hot_addr[$urandom_range(7)];
        endcase
        return a;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_directed_accesses();
        // Cold read: misses in both levels, reads cleared store.
        send_access(OP_READ, 16'h0000, 32'hFFFF_FFFF);
        send_access(OP_WRITE, 16'h0003, 32'hFFFF_FFFF);
        send_access(OP_READ, 16'h0003, 32'h0);
        // Highest address, all-ones and all-zeros data.
        send_access(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
        send_access(OP_READ, 16'hFFFF, 32'h0);
        send_access(OP_WRITE, 16'hFFF0, 32'h0000_0000);
        // Same L1 line, other tag: evicts a dirty L1 line into L2.
        send_access(OP_WRITE, 16'h1003, 32'hA5A5_5A5A);
        send_access(OP_READ, 16'h0003, 32'h0);
        // Same L2 line, other tag: evicts a dirty L2 line to the store.
        send_access(OP_WRITE, 16'h2003, 32'h1234_5678);
        send_access(OP_READ, 16'h4003, 32'h0);
        send_access(OP_READ, 16'h6003, 32'h0);
        send_access(OP_READ, 16'h0003, 32'h0);
        send_access(OP_READ, 16'h2003, 32'h0);
        send_access(OP_READ, 16'h1003, 32'h0);
        send_access(OP_WRITE, 16'h8000, 32'h8000_0001);
        send_access(OP_READ, 16'h7FFF, 32'h0);
        send_access(OP_READ, 16'hF000, 32'h0);
        send_access(OP_READ, 16'h8000, 32'h0);
        drain_results();
    endtask

    task automatic test_cost_registers();
        // Writes past the last register must leave every cost unchanged.
        write_cost(CFG_PAST_LAST_A, 8'hFF);
        write_cost(CFG_PAST_LAST_B, 8'h00);
        send_access(OP_READ, 16'h3000, 32'h0);
        drain_results();
        set_all_costs(8'h00);
        send_access(OP_WRITE, 16'h5005, 32'hDEAD_BEEF);
        send_access(OP_READ, 16'h1005, 32'h0);
        drain_results();
        // Top cost on every level, with both victims dirty.
        set_all_costs(8'hFF);
        send_access(OP_WRITE, 16'h3005, 32'h0F0F_F0F0);
        send_access(OP_READ, 16'h5005, 32'h0);
        send_access(OP_WRITE, 16'h7005, 32'h1);
        send_access(OP_READ, 16'h1005, 32'h0);
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_access($urandom_range(1) ? OP_WRITE : OP_READ, pick_address(), $urandom);
            // Hold off once mid-phase until the block has caught up.
            if (i == count / 2)
                drain_results();
        end
        drain_results();
    endtask

    task automatic load_random_costs();
        write_cost(CFG_L1_RD, COST_W'($urandom));
        write_cost(CFG_L1_WR, COST_W'($urandom));
        write_cost(CFG_L2_RD, COST_W'($urandom));
        write_cost(CFG_L2_WR, COST_W'($urandom));
        write_cost(CFG_ST_RD, COST_W'($urandom));
        write_cost(CFG_ST_WR, COST_W'($urandom));
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = OP_READ;
        s_word_address = '0;
        s_write_word   = '0;
        m_ready        = 1'b1;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_L1_RD;
        cfg_wdata      = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_accesses();
        test_cost_registers();
        load_random_costs();
        test_random_traffic(580, 17, 84);
        set_all_costs(8'h00);
        test_random_traffic(580, 84, 17);
        load_random_costs();
        test_random_traffic(580, 0, 0);

        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/tdmc_pkg.sv
src/tdmc_ram.sv
src/tdmc_cost.sv
src/tdmc_seq.sv
src/two_level_direct_mapped_cache_unit.sv
src/tdmc_checker.sv
test/tb_two_level_direct_mapped_cache_unit.sv
